// ----- rtl/core/scpc_pkg.sv -----
package scpc_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int HELD_BITS = $clog2(SLOTS + 1);
  localparam int PAGE_NUMBER_BITS = 32;
  localparam int LIMIT_BITS = 5;
  localparam int LIMIT_MAX = (SLOTS < 16) ? SLOTS : 16;
  localparam int LIMIT_RESET = 4;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_CLOSE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic [1:0]                  operation;
    logic [PAGE_NUMBER_BITS-1:0] page_number;
  } req_t;

  typedef struct packed {
    logic                        hit;
    logic [3:0]                  slot;
    logic                        need_fill;
    logic                        victim_valid;
    logic [PAGE_NUMBER_BITS-1:0] victim_page;
    logic                        writeback;
    logic                        last;
  } rsp_t;

  typedef struct packed {
    op_t                         op;
    logic [PAGE_NUMBER_BITS-1:0] page;
  } cmd_t;

  function automatic logic [SLOT_BITS-1:0] first_set(input logic [SLOTS-1:0] v);
    logic [SLOT_BITS-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) idx = SLOT_BITS'(i);
    end
    return idx;
  endfunction

endpackage

// ----- rtl/core/scpc_front.sv -----
module scpc_front import scpc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic q_pop
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       cmd_in;

  assign req_stall = (count == 2'd2);
  assign push      = req_valid && !req_stall;
  assign q_valid   = (count != 2'd0);
  assign q_cmd     = entry[rd_ptr];

  always_comb begin
    cmd_in.op   = op_t'(req.operation);
    cmd_in.page = req.page_number;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      unique case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/scpc_back.sv -----
module scpc_back import scpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [LIMIT_BITS-1:0] cfg_wdata,
  input  logic                  q_valid,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp
);

  state_t                      state, state_next;
  cmd_t                        cmd;
  logic [PAGE_NUMBER_BITS-1:0] tags [SLOTS];
  logic [SLOTS-1:0]            valid, valid_next;
  logic [SLOTS-1:0]            used, used_next;
  logic [SLOTS-1:0]            dirty, dirty_next;
  logic [SLOTS-1:0]            pend, pend_next;
  logic [SLOT_BITS-1:0]        hand, hand_next;
  logic [HELD_BITS-1:0]        held, held_next;
  logic [LIMIT_BITS-1:0]       limit;
  logic [SLOTS-1:0]            match;
  logic                        out_free;
  logic                        emit;
  rsp_t                        rsp_next;
  logic                        alloc;
  logic [SLOT_BITS-1:0]        alloc_slot;
  logic                        alloc_vv;
  logic [SLOT_BITS-1:0]        hit_slot;
  logic [SLOT_BITS-1:0]        rep_slot;
  logic [SLOTS-1:0]            rep_rest;
  logic                        is_write;

  assign out_free = !rsp_valid || !rsp_stall;
  assign is_write = (cmd.op == OP_WRITE);
  assign hit_slot = first_set(match);
  assign rep_slot = first_set(pend);
  assign rep_rest = pend & ~(SLOTS'(1) << rep_slot);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = valid[i] && (tags[i] == cmd.page);
    end
  end

  always_comb begin
    state_next = state;
    valid_next = valid;
    used_next  = used;
    dirty_next = dirty;
    pend_next  = pend;
    hand_next  = hand;
    held_next  = held;
    q_pop      = 1'b0;
    emit       = 1'b0;
    rsp_next   = '0;
    alloc      = 1'b0;
    alloc_slot = '0;
    alloc_vv   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.op == OP_FLUSH || q_cmd.op == OP_CLOSE) begin
            pend_next  = valid & dirty;
            state_next = ST_REPORT;
          end else begin
            state_next = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        if (|match) begin
          if (out_free) begin
            used_next[hit_slot] = 1'b1;
            if (is_write) dirty_next[hit_slot] = 1'b1;
            emit          = 1'b1;
            rsp_next.hit  = 1'b1;
            rsp_next.slot = 4'(hit_slot);
            rsp_next.last = 1'b1;
            state_next    = ST_IDLE;
          end
        end else if (HELD_BITS'(limit) <= held) begin
          state_next = ST_SCAN;
        end else if (out_free) begin
          alloc = 1'b1;
          if (|(~valid)) begin
            alloc_slot = first_set(~valid);
          end else begin
            alloc_slot = '0;
            alloc_vv   = 1'b1;
          end
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!valid[hand]) begin
          hand_next = hand + SLOT_BITS'(1);
        end else if (used[hand]) begin
          used_next[hand] = 1'b0;
          hand_next       = hand + SLOT_BITS'(1);
        end else if (out_free) begin
          hand_next  = hand + SLOT_BITS'(1);
          alloc      = 1'b1;
          alloc_slot = hand;
          alloc_vv   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          emit = 1'b1;
          if (pend != '0) begin
            rsp_next.slot         = 4'(rep_slot);
            rsp_next.victim_valid = 1'b1;
            rsp_next.victim_page  = tags[rep_slot];
            rsp_next.writeback    = 1'b1;
            rsp_next.last         = (rep_rest == '0);
            dirty_next[rep_slot]  = 1'b0;
            pend_next             = rep_rest;
          end else begin
            rsp_next.last = 1'b1;
          end
          if (rsp_next.last) begin
            state_next = ST_IDLE;
            if (cmd.op == OP_CLOSE) begin
              valid_next = '0;
              used_next  = '0;
              dirty_next = '0;
              hand_next  = '0;
              held_next  = '0;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (alloc) begin
      emit                   = 1'b1;
      rsp_next.slot          = 4'(alloc_slot);
      rsp_next.need_fill     = !is_write;
      rsp_next.victim_valid  = alloc_vv;
      rsp_next.victim_page   = alloc_vv ? tags[alloc_slot] : '0;
      rsp_next.writeback     = alloc_vv && dirty[alloc_slot];
      rsp_next.last          = 1'b1;
      valid_next[alloc_slot] = 1'b1;
      used_next[alloc_slot]  = 1'b1;
      dirty_next[alloc_slot] = is_write;
      if (!alloc_vv || held == '0) held_next = held + HELD_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (alloc) begin
      tags[alloc_slot] <= cmd.page;
    end
    if (q_pop) begin
      cmd <= q_cmd;
    end
    if (emit) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      used      <= '0;
      dirty     <= '0;
      pend      <= '0;
      hand      <= '0;
      held      <= '0;
      limit     <= LIMIT_BITS'(LIMIT_RESET);
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= valid_next;
      used  <= used_next;
      dirty <= dirty_next;
      pend  <= pend_next;
      hand  <= hand_next;
      held  <= held_next;
      if (cfg_wen) begin
        if (cfg_wdata == '0) begin
          limit <= LIMIT_BITS'(1);
        end else if (cfg_wdata > LIMIT_BITS'(LIMIT_MAX)) begin
          limit <= LIMIT_BITS'(LIMIT_MAX);
        end else begin
          limit <= cfg_wdata;
        end
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/second_chance_page_cache_policy.sv -----
// An access result is registered; a miss that evicts first steps the clock hand
//   over the slots until it finds a valid one whose used bit is clear.
// Accesses are handled one at a time; flush and close return one result per dirty
//   page, or a single result when no page is dirty.
// Reset: synchronous; empties the cache, hand and page count to zero, limit to 4.
module second_chance_page_cache_policy import scpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [LIMIT_BITS-1:0] cfg_wdata,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp
);

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  scpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  scpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ----- test/scpc_policy_checker.sv -----
`timescale 1ns / 1ps
module scpc_policy_checker import scpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [LIMIT_BITS-1:0] cfg_wdata,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  req_t                  req,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  rsp_t                  rsp,
  output int                    fail_count,
  output int                    open_count
);

  localparam int EXP_DEPTH = 256;

  logic [PAGE_NUMBER_BITS-1:0] tag_mem [SLOTS];
  logic [SLOTS-1:0]            valid_q;
  logic [SLOTS-1:0]            used_q;
  logic [SLOTS-1:0]            dirty_q;
  logic [SLOT_BITS-1:0]        hand;
  int                          held;
  logic [LIMIT_BITS-1:0]       limit_reg;
  rsp_t                        exp_mem [EXP_DEPTH];
  int                          exp_wr = 0;
  int                          exp_rd = 0;
  int                          errors = 0;

  function automatic int active_limit();
    int l;
    l = limit_reg;
    if (l < 1) l = 1;
    if (l > LIMIT_MAX) l = LIMIT_MAX;
    return l;
  endfunction

  task automatic add_expected(rsp_t r);
    exp_mem[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endtask

  task automatic report_dirty_pages();
    int   total;
    int   k;
    rsp_t r;
    total = 0;
    k = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (valid_q[i] && dirty_q[i]) total++;
    end
    if (total == 0) begin
      r = '0;
      r.last = 1'b1;
      add_expected(r);
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (valid_q[i] && dirty_q[i]) begin
          k++;
          r = '0;
          r.slot = 4'(i);
          r.victim_valid = 1'b1;
          r.victim_page = tag_mem[i];
          r.writeback = 1'b1;
          r.last = (k == total);
          dirty_q[i] = 1'b0;
          add_expected(r);
        end
      end
    end
  endtask

  task automatic predict_request(req_t item);
    op_t  op;
    logic found;
    logic got;
    logic is_write;
    int   s;
    int   h;
    rsp_t r;
    op = op_t'(item.operation);
    is_write = (op == OP_WRITE);
    found = 1'b0;
    got = 1'b0;
    s = 0;
    r = '0;
    r.last = 1'b1;
    case (op)
      OP_FLUSH: report_dirty_pages();
      OP_CLOSE: begin
        report_dirty_pages();
        valid_q = '0;
        used_q = '0;
        dirty_q = '0;
        hand = '0;
        held = 0;
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && valid_q[i] && tag_mem[i] == item.page_number) begin
            found = 1'b1;
            s = i;
          end
        end
        if (found) begin
          used_q[s] = 1'b1;
          if (is_write) dirty_q[s] = 1'b1;
          r.hit = 1'b1;
          r.slot = 4'(s);
          add_expected(r);
        end else begin
          if (held >= active_limit()) begin
            for (int n = 0; n < 2 * SLOTS + 1 && !got; n++) begin
              h = hand;
              hand = SLOT_BITS'((h + 1) % SLOTS);
              if (valid_q[h]) begin
                if (used_q[h]) used_q[h] = 1'b0;
                else begin
                  s = h;
                  got = 1'b1;
                end
              end
            end
            if (got) begin
              r.victim_valid = 1'b1;
              r.victim_page = tag_mem[s];
              r.writeback = dirty_q[s];
              valid_q[s] = 1'b0;
              held--;
            end
          end
          if (!got) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!found && !valid_q[i]) begin
                found = 1'b1;
                s = i;
              end
            end
          end
          tag_mem[s] = item.page_number;
          valid_q[s] = 1'b1;
          used_q[s] = 1'b1;
          dirty_q[s] = is_write;
          held++;
          r.slot = 4'(s);
          r.need_fill = !is_write;
          add_expected(r);
        end
      end
    endcase
  endtask

  task automatic check_result(rsp_t got);
    rsp_t want;
    if (exp_wr == exp_rd) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected hit=%0b slot=%0d fill=%0b vv=%0b page=%h wb=%0b last=%0b",
                 $realtime, got.hit, got.slot, got.need_fill, got.victim_valid,
                 got.victim_page, got.writeback, got.last);
    end else begin
      want = exp_mem[exp_rd % EXP_DEPTH];
      exp_rd++;
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch", $realtime);
          $display("  expected hit=%0b slot=%0d fill=%0b vv=%0b page=%h wb=%0b last=%0b",
                   want.hit, want.slot, want.need_fill, want.victim_valid,
                   want.victim_page, want.writeback, want.last);
          $display("  actual   hit=%0b slot=%0d fill=%0b vv=%0b page=%h wb=%0b last=%0b",
                   got.hit, got.slot, got.need_fill, got.victim_valid,
                   got.victim_page, got.writeback, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      valid_q = '0;
      used_q = '0;
      dirty_q = '0;
      hand = '0;
      held = 0;
      limit_reg = LIMIT_BITS'(LIMIT_RESET);
      exp_wr = 0;
      exp_rd = 0;
    end else begin
      if (rsp_valid && !rsp_stall) check_result(rsp);
      if (cfg_wen) limit_reg = cfg_wdata;
      if (req_valid && !req_stall) predict_request(req);
    end
    fail_count <= errors;
    open_count <= exp_wr - exp_rd;
  end

endmodule

// ----- test/second_chance_page_cache_policy_tb.sv -----
`timescale 1ns / 1ps
module second_chance_page_cache_policy_tb;
  import scpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOT_PAGES = 24;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wen = 1'b0;
  logic [LIMIT_BITS-1:0] cfg_wdata = '0;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  req_t                  req = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  rsp_t                  rsp;
  int                    fail_count;
  int                    open_count;
  int                    idle_cycles = 0;
  bit                    quiet = 1'b0;
  bit                    hold_request = 1'b0;
  logic [31:0]           hot_pages [HOT_PAGES];
  int                    limits [7] = '{0, 31, 16, 2, 1, 17, 9};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  second_chance_page_cache_policy i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  scpc_policy_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** second_chance_page_cache_policy: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int pick;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_stall <= 1'b0;
      end else if (!quiet) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          rsp_stall <= 1'b1;
          repeat ($urandom_range(1, 10)) @(posedge clk);
          rsp_stall <= 1'b0;
        end else if (pick == 2) begin
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end
      end
    end
  end

  task automatic send_item(op_t op, logic [31:0] page);
    req_t item;
    item.operation = op;
    item.page_number = page;
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic random_item();
    int          sel;
    op_t         op;
    logic [31:0] page;
    sel = $urandom_range(0, 99);
    op = (sel < 50) ? OP_READ : (sel < 85) ? OP_WRITE : (sel < 94) ? OP_FLUSH : OP_CLOSE;
    page = ($urandom_range(0, 4) == 0) ? $urandom : hot_pages[$urandom_range(0, HOT_PAGES - 1)];
    send_item(op, page);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_limit(int value);
    cfg_wen <= 1'b1;
    cfg_wdata <= LIMIT_BITS'(value);
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < HOT_PAGES; i++) hot_pages[i] = $urandom;
    hot_pages[0] = 32'h0000_0000;
    hot_pages[1] = 32'hFFFF_FFFF;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_item(OP_FLUSH, 32'h0000_0000);
    send_item(OP_CLOSE, 32'hFFFF_FFFF);
    send_item(OP_READ, 32'h0000_0000);
    send_item(OP_READ, 32'h0000_0000);
    send_item(OP_WRITE, 32'hFFFF_FFFF);
    send_item(OP_WRITE, 32'h0000_0000);
    send_item(OP_READ, 32'h8000_0001);
    send_item(OP_READ, 32'h7FFF_FFFE);
    send_item(OP_READ, 32'h0000_1000);
    send_item(OP_WRITE, 32'h5555_5555);
    send_item(OP_READ, 32'h8000_0001);
    send_item(OP_READ, 32'hAAAA_AAAA);
    send_item(OP_FLUSH, 32'h1234_5678);
    send_item(OP_FLUSH, 32'h0000_0000);
    send_item(OP_WRITE, 32'h1234_5678);
    send_item(OP_WRITE, 32'hFFFF_FFFF);
    send_item(OP_CLOSE, 32'h0000_0000);
    send_item(OP_READ, 32'h0000_1000);
    send_item(OP_CLOSE, 32'h0000_0000);

    for (int p = 0; p < 7; p++) begin
      wait_idle();
      write_limit(limits[p]);
      if (p == 6) quiet = 1'b1;
      if (limits[p] == 16) begin
        hold_request = 1'b1;
        while (!rsp_stall) @(posedge clk);
        quiet = 1'b1;
        repeat (24) random_item();
        quiet = 1'b0;
      end
      repeat (9) random_item();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("** second_chance_page_cache_policy: PASSED **");
    end else begin
      $display("** second_chance_page_cache_policy: FAILED **");
    end
    $finish;
  end

endmodule

// ----- second_chance_page_cache_policy.f -----
rtl/core/scpc_pkg.sv
rtl/core/scpc_front.sv
rtl/core/scpc_back.sv
rtl/core/second_chance_page_cache_policy.sv
test/scpc_policy_checker.sv
test/second_chance_page_cache_policy_tb.sv
